// ===== rtl/core/tadmd_pkg.sv =====
// ============================================================================
// tadmd_pkg: shared types and constants for the tilt angle motor drive
// Register indexes, field widths, reset values, drive codes, the sequencer
// state type and the CORDIC arctangent table in degrees.
// ============================================================================
package tadmd_pkg;

    // Default parameter values for the top level.
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 16;

    // Field widths.
    localparam int ANGLE_W  = 9;    // configured angle limits
    localparam int RATIO_W  = 17;   // smoothing weight, unsigned Q1.16
    localparam int DBAND_W  = 16;   // deadband half width
    localparam int VOL_W    = 18;   // volume, signed Q2.16
    localparam int DRIVE_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;

    // CORDIC angle accumulator (degrees, 16 fraction bits) and Q9.7 result.
    localparam int ZW    = 27;
    localparam int ANG_W = 16;
    localparam logic signed [ZW-1:0] HALF_TURN_Q16 = 27'sd11796480;
    localparam logic signed [ZW-1:0] HALF_TURN_Q7  = 27'sd23040;
    localparam logic signed [ZW-1:0] ROUND_Q7      = 27'sd256;

    // Volume limits.
    localparam logic signed [VOL_W-1:0] VOL_MAX = 18'sh1FFFF;
    localparam logic signed [VOL_W-1:0] VOL_MIN = 18'sh20000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd4;

    // Configuration reset values.
    localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST = 9'h192;   // -110 degrees
    localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST = 9'd165;
    localparam logic [RATIO_W-1:0] SMOOTH_RST    = 17'd1311;
    localparam logic [RATIO_W-1:0] RATIO_ONE     = 17'd65536;
    localparam logic [DBAND_W-1:0] DEADBAND_RST  = 16'd131;
    localparam logic [VOL_W-1:0]   TARGET_RST    = 18'd0;

    // Motor drive codes.
    localparam logic [DRIVE_W-1:0] DRIVE_STOP  = 2'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_LEFT  = 2'd1;
    localparam logic [DRIVE_W-1:0] DRIVE_RIGHT = 2'd2;

    // Input action codes.
    localparam logic ACT_REGULATE = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORD,
        S_PREP,
        S_DIV,
        S_SAT,
        S_MUL,
        S_UPD,
        S_DRIVE,
        S_OUT
    } t_state;

    // Result of the angle unit: a one-cycle done strobe and the Q9.7 angle.
    typedef struct packed {
        logic                    done;
        logic signed [ANG_W-1:0] angle;
    } t_cordic_res;

    // atan(2^-i) in degrees with 16 fraction bits.
    function automatic logic signed [ZW-1:0] atan_deg_q16(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:  v = 27'sd2949120;
            5'd1:  v = 27'sd1740967;
            5'd2:  v = 27'sd919879;
            5'd3:  v = 27'sd466945;
            5'd4:  v = 27'sd234379;
            5'd5:  v = 27'sd117304;
            5'd6:  v = 27'sd58666;
            5'd7:  v = 27'sd29335;
            5'd8:  v = 27'sd14668;
            5'd9:  v = 27'sd7334;
            5'd10: v = 27'sd3667;
            5'd11: v = 27'sd1833;
            5'd12: v = 27'sd917;
            5'd13: v = 27'sd458;
            5'd14: v = 27'sd229;
            5'd15: v = 27'sd115;
            5'd16: v = 27'sd57;
            5'd17: v = 27'sd29;
            5'd18: v = 27'sd14;
            5'd19: v = 27'sd7;
            5'd20: v = 27'sd4;
            5'd21: v = 27'sd2;
            5'd22: v = 27'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/tadmd_cordic.sv =====
// ============================================================================
// tadmd_cordic: iterative vectoring CORDIC for the tilt angle
// Rotates the sample vector onto the positive x axis one micro-rotation per
// cycle with a single shift/add datapath, then rounds the accumulated angle
// to Q9.7 degrees and clamps it to a half turn.
// ============================================================================
module tadmd_cordic #(
    parameter int CORDIC_STEPS = tadmd_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS  = tadmd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SAMPLE_BITS-1:0] i_ax,
    input  logic signed [SAMPLE_BITS-1:0] i_ay,
    output tadmd_pkg::t_cordic_res        o_res
);
    import tadmd_pkg::*;

    // Samples are scaled by 2^16; three more bits cover sign and CORDIC gain.
    localparam int XW     = SAMPLE_BITS + 19;
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic signed [XW-1:0]    r_x, r_y;
    logic signed [ZW-1:0]    r_z;
    logic [STEP_W-1:0]       r_cnt;
    logic                    r_run, r_round, r_done, r_zero;
    logic signed [ANG_W-1:0] r_angle;

    logic signed [XW-1:0] x0, y0, sx, sy;
    logic signed [ZW-1:0] atan_v, z_rnd;
    logic                 rot_pos;

    assign x0 = {{3{i_ax[SAMPLE_BITS-1]}}, i_ax, 16'b0};
    assign y0 = {{3{i_ay[SAMPLE_BITS-1]}}, i_ay, 16'b0};

    assign sx      = r_x >>> r_cnt;
    assign sy      = r_y >>> r_cnt;
    assign atan_v  = atan_deg_q16(5'(r_cnt));
    assign rot_pos = !r_y[XW-1] && (r_y != '0);
    assign z_rnd   = (r_z + ROUND_Q7) >>> 9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_round <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done  <= r_round;
            r_round <= r_run && (r_cnt == LAST_STEP);
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == LAST_STEP)) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // A vector in the left half plane is mirrored and starts at a half turn.
            r_cnt  <= '0;
            r_zero <= (i_ax == '0) && (i_ay == '0);
            if (i_ax[SAMPLE_BITS-1]) begin
                r_x <= -x0;
                r_y <= -y0;
                r_z <= i_ay[SAMPLE_BITS-1] ? -HALF_TURN_Q16 : HALF_TURN_Q16;
            end else begin
                r_x <= x0;
                r_y <= y0;
                r_z <= '0;
            end
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
            if (rot_pos) begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + atan_v;
            end else begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - atan_v;
            end
        end
        if (r_round) begin
            if (r_zero) begin
                r_angle <= '0;
            end else if (z_rnd > HALF_TURN_Q7) begin
                r_angle <= ANG_W'(HALF_TURN_Q7);
            end else if (z_rnd < -HALF_TURN_Q7) begin
                r_angle <= ANG_W'(-HALF_TURN_Q7);
            end else begin
                r_angle <= ANG_W'(z_rnd);
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.angle = r_angle;

endmodule

// ===== rtl/core/tilt_angle_deadband_motor_drive.sv =====
// ============================================================================
// tilt_angle_deadband_motor_drive: tilt angle to volume with motor drive
// Finds the tilt angle of two accelerometer samples, maps it to a volume,
// smooths the volume and drives a motor toward a target with a deadband.
// ============================================================================
//
//  Channel   Direction  Handshake                   Payload
//  input     in         i_in_valid / o_in_ready     i_action, i_accel_y, i_accel_z
//  output    out        o_out_valid / i_out_ready   o_volume, o_drive
//  config    in         i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
//  A transfer's result comes from the one-step-per-cycle CORDIC and the
//  two-bits-per-cycle divider; o_in_ready rises with the result, so an item
//  is taken only once the one before it is through.
//  A waiting result sits in the output register while the next item runs;
//  that item then holds in its last step until the result is taken.
//  Synchronous active-low reset clears control state, loads the register defaults.
//
module tilt_angle_deadband_motor_drive #(
    parameter int CORDIC_STEPS = tadmd_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS  = tadmd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_action,
    input  logic signed [SAMPLE_BITS-1:0]         i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0]         i_accel_z,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [tadmd_pkg::VOL_W-1:0]    o_volume,
    output logic [tadmd_pkg::DRIVE_W-1:0]         o_drive,
    input  logic                                  i_cfg_we,
    input  logic [tadmd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tadmd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import tadmd_pkg::*;

    // Divider: 27-bit dividend padded to an even width, two quotient bits a cycle.
    localparam int DIVW      = 28;
    localparam int DIV_STEPS = DIVW / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int REM_W     = 10;
    localparam int NUM_W     = 26;
    localparam int PROD_W    = 37;
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);
    localparam logic [DIVW-1:0]   Q_POS_MAX = DIVW'(131071);
    localparam logic [DIVW-1:0]   Q_NEG_MAX = DIVW'(131072);

    t_state r_state, n_state;

    // Configuration registers.
    logic [ANGLE_W-1:0] r_min_angle, r_max_angle;
    logic [RATIO_W-1:0] r_smooth;
    logic [DBAND_W-1:0] r_deadband;
    logic [VOL_W-1:0]   r_target;

    // Datapath registers.
    logic                    r_action;
    logic                    r_neg, r_dzero;
    logic [REM_W-1:0]        r_dvs, r_rem;
    logic [DIVW-1:0]         r_quo;
    logic [DCNT_W-1:0]       r_cnt;
    logic signed [VOL_W-1:0] r_raw, r_avg;
    logic signed [PROD_W-1:0] r_prod;
    logic                    r_primed;
    logic [DRIVE_W-1:0]      r_motor;
    logic                    r_out_valid;
    logic signed [VOL_W-1:0] r_out_volume;
    logic [DRIVE_W-1:0]      r_out_drive;

    // Sequencer decodes.
    logic in_xfer, out_load;

    t_cordic_res cres;

    tadmd_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(in_xfer),
        .i_ax   (i_accel_y),
        .i_ay   (i_accel_z),
        .o_res  (cres)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CORD;
            S_CORD:  if (cres.done) n_state = S_PREP;
            S_PREP:  n_state = S_DIV;
            S_DIV:   if (r_cnt == DIV_LAST) n_state = S_SAT;
            S_SAT:   n_state = S_MUL;
            S_MUL:   n_state = S_UPD;
            S_UPD:   n_state = S_DRIVE;
            S_DRIVE: n_state = S_OUT;
            S_OUT:   if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        in_xfer    = (r_state == S_IDLE) && i_in_valid;
        out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------ configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_angle <= MIN_ANGLE_RST;
            r_max_angle <= MAX_ANGLE_RST;
            r_smooth    <= SMOOTH_RST;
            r_deadband  <= DEADBAND_RST;
            r_target    <= TARGET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_ANGLE: r_min_angle <= i_cfg_data[ANGLE_W-1:0];
                CFG_MAX_ANGLE: r_max_angle <= i_cfg_data[ANGLE_W-1:0];
                CFG_SMOOTH:    r_smooth    <= i_cfg_data[RATIO_W-1:0];
                CFG_DEADBAND:  r_deadband  <= i_cfg_data[DBAND_W-1:0];
                CFG_TARGET:    r_target    <= i_cfg_data[VOL_W-1:0];
                default: ;
            endcase
        end
    end

    // -------------------------------------------------------- angle to numerator
    logic signed [ANG_W-1:0]   lo_q7;
    logic signed [ANG_W:0]     ang_off;
    logic signed [NUM_W-1:0]   num;
    logic [NUM_W-1:0]          num_mag;
    logic signed [ANGLE_W:0]   den;
    logic [ANGLE_W-1:0]        den_mag;

    always_comb begin
        lo_q7   = {r_min_angle, 7'b0};
        ang_off = (ANG_W + 1)'(cres.angle) - (ANG_W + 1)'(lo_q7);
        num     = {ang_off, 9'b0};
        num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        den     = (ANGLE_W + 1)'(signed'(r_max_angle)) - (ANGLE_W + 1)'(signed'(r_min_angle));
        den_mag = den[ANGLE_W] ? ANGLE_W'(-den) : ANGLE_W'(den);
    end

    // ------------------------------------------------------ restoring divider
    logic [REM_W:0]   div_t;
    logic [REM_W-1:0] n_rem;
    logic [DIVW-1:0]  n_quo;

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        div_t = '0;
        for (int k = 0; k < 2; k++) begin
            div_t = {n_rem, n_quo[DIVW-1]};
            n_quo = {n_quo[DIVW-2:0], 1'b0};
            if (div_t >= {1'b0, r_dvs}) begin
                div_t    = div_t - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
            n_rem = div_t[REM_W-1:0];
        end
    end

    // -------------------------------------------------- saturate and smooth
    logic signed [VOL_W-1:0]  raw_sat;
    logic [RATIO_W-1:0]       ratio;
    logic signed [VOL_W:0]    vol_diff;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [20:0]       avg_step;
    logic signed [21:0]       avg_sum;
    logic signed [VOL_W-1:0]  avg_next;
    logic signed [VOL_W:0]    tgt_diff, db_pos;

    always_comb begin
        if (r_dzero) begin
            raw_sat = '0;
        end else if (r_neg) begin
            raw_sat = (r_quo > Q_NEG_MAX) ? VOL_MIN : -VOL_W'(r_quo);
        end else begin
            raw_sat = (r_quo > Q_POS_MAX) ? VOL_MAX : VOL_W'(r_quo);
        end

        ratio    = (r_smooth > RATIO_ONE) ? RATIO_ONE : r_smooth;
        vol_diff = (VOL_W + 1)'(r_raw) - (VOL_W + 1)'(r_avg);

        // Round the weighted step to nearest by adding half before the shift.
        prod_rnd = r_prod + PROD_W'(32768);
        avg_step = prod_rnd[PROD_W-1:16];
        avg_sum  = 22'(r_avg) + 22'(avg_step);
        if (avg_sum > 22'(VOL_MAX)) begin
            avg_next = VOL_MAX;
        end else if (avg_sum < 22'(VOL_MIN)) begin
            avg_next = VOL_MIN;
        end else begin
            avg_next = VOL_W'(avg_sum);
        end

        tgt_diff = (VOL_W + 1)'(signed'(r_target)) - (VOL_W + 1)'(r_avg);
        db_pos   = signed'({3'b0, r_deadband});
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_action <= i_action;
        end
        if (r_state == S_PREP) begin
            r_cnt   <= '0;
            r_dzero <= (den == '0);
            r_neg   <= num[NUM_W-1] ^ den[ANGLE_W];
            r_dvs   <= {den_mag, 1'b0};
            r_rem   <= '0;
            r_quo   <= DIVW'({num_mag, 1'b0}) + DIVW'(den_mag);
        end else if (r_state == S_DIV) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (r_state == S_SAT) begin
            r_raw <= raw_sat;
        end
        if (r_state == S_MUL) begin
            r_prod <= signed'({1'b0, ratio}) * vol_diff;
        end
        if (out_load) begin
            r_out_volume <= r_avg;
            r_out_drive  <= r_motor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg       <= '0;
            r_primed    <= 1'b0;
            r_motor     <= DRIVE_STOP;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_UPD) begin
                // The first sample after reset loads the average directly.
                r_avg    <= r_primed ? avg_next : r_raw;
                r_primed <= 1'b1;
            end
            if (r_state == S_DRIVE && r_action == ACT_REGULATE) begin
                if (tgt_diff > db_pos) begin
                    r_motor <= DRIVE_RIGHT;
                end else if (tgt_diff < -db_pos) begin
                    r_motor <= DRIVE_LEFT;
                end else begin
                    r_motor <= DRIVE_STOP;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_volume    = r_out_volume;
    assign o_drive     = r_out_drive;

    // -------------------------------------------------------------- assertions
    a_start_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CORD))
        else $error("transfer did not start the angle unit");

    a_motor_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_motor == DRIVE_STOP) || (r_motor == DRIVE_LEFT) || (r_motor == DRIVE_RIGHT))
        else $error("motor state holds an unused code");

    a_report_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRIVE && r_action != ACT_REGULATE) |=> $stable(r_motor))
        else $error("report item changed the motor state");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result appeared outside the final step");

    a_primed_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> r_primed)
        else $error("average update left the block unprimed");

endmodule

// ===== tb/tilt_angle_deadband_motor_drive_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tilt_angle_deadband_motor_drive_tb: self-checking bench for the tilt drive
// Sends accelerometer samples under random sender bursts and receiver stalls.
// A scoreboard predicts the smoothed volume and motor drive of every sample
// and checks each result in order. The configuration is changed between
// phases, covering the range extremes.
// ============================================================================
module tilt_angle_deadband_motor_drive_tb;
    import tadmd_pkg::*;

    localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int UNITY_WEIGHT = 65536;
    localparam logic ACT_REPORT = ~ACT_REGULATE;

    // atan(2^-i) in degrees, 16 fraction bits.
    localparam longint ATAN_STEP_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // Directed samples: zero vector, axis extremes, both sides of the +-180 cut.
    localparam int DIR_Y [18] = '{0, 32767, -32768, -32768, 0, 0, -32768, 32767,
                                  -32768, 32767, 1, 0, -1, 0, -1, 1, -1, 12000};
    localparam int DIR_Z [18] = '{0, 0, 0, -1, 32767, -32768, -32768, 32767,
                                  32767, -32768, 0, 1, 0, -1, -1, 1, 1, -7000};
    localparam int EDGE_VALS [5] = '{-32768, -1, 0, 1, 32767};

    typedef struct packed {
        logic signed [VOL_W-1:0] volume;
        logic [DRIVE_W-1:0]      drive;
    } t_vol_drive;

    class drive_scoreboard;
        logic signed [ANGLE_W-1:0] min_deg;
        logic signed [ANGLE_W-1:0] max_deg;
        logic [RATIO_W-1:0]        ratio;
        logic [DBAND_W-1:0]        band;
        logic signed [VOL_W-1:0]   target;
        longint                    avg_vol;
        bit                        primed;
        logic [DRIVE_W-1:0]        motor;
        t_vol_drive                vol_drive_q[$];
        int                        mismatches;
        int                        results_seen;

        function new();
            min_deg      = -9'sd110;
            max_deg      = 9'sd165;
            ratio        = 17'd1311;
            band         = 16'd131;
            target       = '0;
            avg_vol      = 0;
            primed       = 1'b0;
            motor        = DRIVE_STOP;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MIN_ANGLE: min_deg = data[ANGLE_W-1:0];
                CFG_MAX_ANGLE: max_deg = data[ANGLE_W-1:0];
                CFG_SMOOTH:    ratio   = data[RATIO_W-1:0];
                CFG_DEADBAND:  band    = data[DBAND_W-1:0];
                CFG_TARGET:    target  = data[VOL_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_vol(longint v);
            if (v > longint'(VOL_MAX)) return longint'(VOL_MAX);
            if (v < longint'(VOL_MIN)) return longint'(VOL_MIN);
            return v;
        endfunction

        // Vectoring CORDIC, angle of (ax, ay) in Q9.7 degrees.
        function longint tilt_q7(longint ax, longint ay);
            longint x, y, z, nx, ang;
            if (ax == 0 && ay == 0) return 0;
            x = ax * 65536;
            y = ay * 65536;
            z = 0;
            // Left half plane: rotate by a half turn first.
            if (x < 0) begin
                z = (y >= 0) ? longint'(HALF_TURN_Q16) : -longint'(HALF_TURN_Q16);
                x = -x;
                y = -y;
            end
            for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
                if (y > 0) begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + ATAN_STEP_DEG[i];
                end else begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - ATAN_STEP_DEG[i];
                end
                x = nx;
            end
            ang = (z + 256) >>> 9;
            if (ang > longint'(HALF_TURN_Q7)) ang = longint'(HALF_TURN_Q7);
            else if (ang < -longint'(HALF_TURN_Q7)) ang = -longint'(HALF_TURN_Q7);
            return ang;
        endfunction

        // Linear map, rounded to nearest with ties away from zero.
        function longint angle_to_volume(longint ang);
            longint lo, hi, num, den, n, d, q;
            lo  = longint'(min_deg);
            hi  = longint'(max_deg);
            den = hi - lo;
            if (den == 0) return 0;
            num = (ang - lo * 128) * 512;
            n   = (num < 0) ? -num : num;
            d   = (den < 0) ? -den : den;
            q   = (2 * n + d) / (2 * d);
            if ((num < 0) != (den < 0)) q = -q;
            return clamp_vol(q);
        endfunction

        function void note_sample(logic act, logic signed [SAMPLE_W-1:0] ay,
                                  logic signed [SAMPLE_W-1:0] az);
            longint     raw, w, diff;
            t_vol_drive want;
            raw = angle_to_volume(tilt_q7(longint'(ay), longint'(az)));
            if (!primed) begin
                avg_vol = raw;
                primed  = 1'b1;
            end else begin
                w = (ratio > UNITY_WEIGHT) ? longint'(UNITY_WEIGHT) : longint'(ratio);
                avg_vol = clamp_vol(avg_vol + ((w * (raw - avg_vol) + 32768) >>> 16));
            end
            if (act == ACT_REGULATE) begin
                diff = longint'(target) - avg_vol;
                if (diff > longint'(band)) motor = DRIVE_RIGHT;
                else if (diff < -longint'(band)) motor = DRIVE_LEFT;
                else motor = DRIVE_STOP;
            end
            want.volume = avg_vol[VOL_W-1:0];
            want.drive  = motor;
            vol_drive_q.push_back(want);
        endfunction

        function void check_result(logic signed [VOL_W-1:0] vol, logic [DRIVE_W-1:0] drv);
            t_vol_drive want;
            results_seen++;
            if (vol_drive_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d with no sample pending: volume %0d drive %0d",
                             results_seen, vol, drv);
                return;
            end
            want = vol_drive_q.pop_front();
            if (vol !== want.volume || drv !== want.drive) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: volume exp %0d got %0d, drive exp %0d got %0d",
                             results_seen, want.volume, vol, want.drive, drv);
            end
        endfunction

        function int pending();
            return vol_drive_q.size();
        endfunction
    endclass

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          i_action   = 1'b0;
    logic signed [SAMPLE_W-1:0]    i_accel_y  = '0;
    logic signed [SAMPLE_W-1:0]    i_accel_z  = '0;
    logic                          i_out_ready = 1'b0;
    logic                          i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic signed [VOL_W-1:0]       o_volume;
    logic [DRIVE_W-1:0]            o_drive;

    logic [1:0]                    rx_mode = 2'd0;
    logic [4:0]                    rx_tick = '0;
    int                            cycle_cnt = 0;
    bit                            tx_bursty;
    int                            burst_left;
    logic signed [SAMPLE_W-1:0]    base_y;
    logic signed [SAMPLE_W-1:0]    base_z;

    drive_scoreboard sb = new();

    tilt_angle_deadband_motor_drive DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_volume    (o_volume),
        .o_drive     (o_drive),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: always ready, light random stalls, long periodic stalls, or coin flips.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 5'd1;
        case (rx_mode)
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: i_out_ready <= (rx_tick >= 5'd21);
            default: i_out_ready <= $urandom_range(0, 1);
        endcase
    end

    // Every transfer and register write is seen here, at the edge it happens.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.set_reg(i_cfg_idx, i_cfg_data);
            if (i_in_valid && o_in_ready) sb.note_sample(i_action, i_accel_y, i_accel_z);
            if (o_out_valid && i_out_ready) sb.check_result(o_volume, o_drive);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tilt_angle_deadband_motor_drive_tb: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input int deg_lo, input int deg_hi, input int weight,
                                  input int half_band, input int hold_vol);
        write_reg(CFG_MIN_ANGLE, deg_lo);
        write_reg(CFG_MAX_ANGLE, deg_hi);
        write_reg(CFG_SMOOTH, weight);
        write_reg(CFG_DEADBAND, half_band);
        write_reg(CFG_TARGET, hold_vol);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_random_settings();
        int deg_lo, deg_hi, weight, half_band, hold_vol;
        deg_lo = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 511)) - 256
                                             : int'($urandom_range(0, 360)) - 180;
        deg_hi = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 511)) - 256
                                             : int'($urandom_range(0, 360)) - 180;
        if ($urandom_range(0, 7) == 0) deg_hi = deg_lo;
        case ($urandom_range(0, 3))
            0: weight = $urandom_range(0, 4000);
            1: weight = $urandom_range(0, 65536);
            2: weight = UNITY_WEIGHT;
            default: weight = $urandom_range(0, 131071);
        endcase
        half_band = $urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom_range(0, 65535);
        hold_vol  = $urandom_range(0, 1) ? int'($urandom_range(0, 65536))
                                         : int'($urandom_range(0, 262143)) - 131072;
        apply_settings(deg_lo, deg_hi, weight, half_band, hold_vol);
    endtask

    // Holds valid and the payload until the transfer happens.
    task automatic send_sample(input logic act, input logic signed [SAMPLE_W-1:0] y,
                               input logic signed [SAMPLE_W-1:0] z);
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_accel_y  <= y;
        i_accel_z  <= z;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Bursts of back-to-back samples, then a gap; some gaps outlast a whole item.
    task automatic pace_sender(input bit last);
        int gap;
        gap = 0;
        if (tx_bursty) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 7);
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
            end
        end
        if (last && gap == 0) gap = 1;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_sample(input bit last);
        logic signed [SAMPLE_W-1:0] y, z;
        logic act;
        act = $urandom_range(0, 1);
        case ($urandom_range(0, 9))
            // Steady tilt with jitter, so the average settles and the deadband matters.
            0, 1, 2, 3: begin
                y = base_y + SAMPLE_W'($urandom_range(0, 64) - 32);
                z = base_z + SAMPLE_W'($urandom_range(0, 64) - 32);
            end
            4, 5, 6: begin
                y = SAMPLE_W'($urandom);
                z = SAMPLE_W'($urandom);
            end
            7: begin
                y = SAMPLE_W'($urandom_range(0, 16) - 8);
                z = SAMPLE_W'($urandom_range(0, 16) - 8);
            end
            8: begin
                y = SAMPLE_W'(EDGE_VALS[$urandom_range(0, 4)]);
                z = SAMPLE_W'(EDGE_VALS[$urandom_range(0, 4)]);
            end
            default: begin
                // Near the negative first axis, where the angle wraps at +-180.
                y = SAMPLE_W'(-int'($urandom_range(1, 32768)));
                z = SAMPLE_W'($urandom_range(0, 6) - 3);
                if ($urandom_range(0, 1)) begin
                    y = SAMPLE_W'($urandom);
                    z = '0;
                end
            end
        endcase
        send_sample(act, y, z);
        pace_sender(last);
    endtask

    // Settle: all results back, then an idle gap before the block is touched again.
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n_items);
        tx_bursty  = ($urandom_range(0, 2) != 0);
        burst_left = 0;
        rx_mode   <= 2'($urandom_range(0, 3));
        base_y     = SAMPLE_W'($urandom);
        base_z     = SAMPLE_W'($urandom);
        for (int k = 0; k < n_items; k++) send_random_sample(k == n_items - 1);
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings; the first sample loads the average directly.
        tx_bursty  = 1'b1;
        burst_left = 0;
        rx_mode   <= 2'd1;
        for (int k = 0; k < 18; k++) begin
            send_sample((k % 3 == 2) ? ACT_REPORT : ACT_REGULATE,
                        SAMPLE_W'(DIR_Y[k]), SAMPLE_W'(DIR_Z[k]));
            pace_sender(k == 17);
        end
        wait_drained();

        // Full span, unity weight, zero deadband, top target.
        apply_settings(-180, 180, UNITY_WEIGHT, 0, 131071);
        run_phase(15);
        // Equal limits, zero weight, widest deadband, bottom target.
        apply_settings(45, 45, 0, 65535, -131072);
        run_phase(15);
        // Reversed limits and an oversized weight.
        apply_settings(180, -180, 131071, 1, 0);
        run_phase(15);
        // Steep slope that saturates the volume at the top end.
        apply_settings(-180, -179, UNITY_WEIGHT, 200, 65536);
        run_phase(15);

        for (int p = 0; p < 10; p++) begin
            apply_random_settings();
            run_phase(48);
        end

        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tilt_angle_deadband_motor_drive_tb: done, clean");
        end else begin
            if (sb.pending() != 0)
                $display("ERROR: %0d expected results never arrived", sb.pending());
            $display("tilt_angle_deadband_motor_drive_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== tilt_angle_deadband_motor_drive.f =====
rtl/core/tadmd_pkg.sv
rtl/core/tadmd_cordic.sv
rtl/core/tilt_angle_deadband_motor_drive.sv
tb/tilt_angle_deadband_motor_drive_tb.sv
